/* rtl/cet_pkg.sv */
// cet_pkg: shared types, codes and character constants of the comparison
// expression tokenizer. No dependencies.
package cet_pkg;

    localparam int MAX_RES   = 3;
    localparam int RUN_CNT_W = $clog2(MAX_RES + 1);
    localparam int QDEPTH    = 4;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_CONST = 3'd2,
        MODE_GT    = 3'd3,
        MODE_LT    = 3'd4,
        MODE_EQ    = 3'd5,
        MODE_BANG  = 3'd6,
        MODE_DRAIN = 3'd7
    } t_mode;

    typedef enum logic [3:0] {
        K_END   = 4'd0,
        K_IDENT = 4'd1,
        K_CONST = 4'd2,
        K_MINUS = 4'd3,
        K_PLUS  = 4'd4,
        K_GT    = 4'd5,
        K_GEQ   = 4'd6,
        K_LT    = 4'd7,
        K_LEQ   = 4'd8,
        K_EQ    = 4'd9,
        K_NEQ   = 4'd10,
        K_BAD   = 4'd11,
        K_EXPEQ = 4'd12
    } t_kind;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       is_final;
    } t_src_item;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic        last_of_run;
    } t_tok_item;

    // results caused by one source byte, in order
    typedef struct packed {
        logic [RUN_CNT_W-1:0]        count;
        t_tok_item [MAX_RES-1:0]     tok;
    } t_run;

    function automatic t_tok_item mk_tok(t_kind kind, logic [15:0] start,
                                         logic [15:0] len);
        t_tok_item t;
        t.token_kind   = kind;
        t.start_offset = start;
        t.token_length = len;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == CH_SPACE) || (b inside {[CH_TAB:CH_CR]});
    endfunction

endpackage

/* rtl/cet_stream_if.sv */
// cet_stream_if: valid/ready channel carrying one payload per transfer.
// Payload type is a parameter; used with cet_pkg types.
interface cet_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/cet_in_reg.sv */
// cet_in_reg: input register of the tokenizer; holds one source byte until
// the scanner takes it. Depends on cet_pkg and cet_stream_if.
module cet_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cet_stream_if.sink         i_src,
    input  logic               i_take,
    output logic               o_valid,
    output cet_pkg::t_src_item o_item
);
    logic               r_valid;
    cet_pkg::t_src_item r_item;

    assign i_src.ready = !r_valid || i_take;
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_src.ready) begin
            r_valid <= i_src.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.valid && i_src.ready) begin
            r_item <= i_src.data;
        end
    end
endmodule

/* rtl/cet_scan.sv */
// cet_scan: scanner state and single-pass token logic for one byte.
// Depends on cet_pkg.
module cet_scan #(
    parameter longint unsigned MAX_POS = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  cet_pkg::t_src_item i_item,
    output cet_pkg::t_run      o_run
);
    localparam int POS_W = $clog2(MAX_POS + 64'd1);
    localparam int EXT_W = (POS_W > 16) ? POS_W : 16;
    localparam logic [POS_W-1:0] MAX_P = POS_W'(MAX_POS);
    localparam int NSLOT = 4;

    function automatic logic [15:0] out16(logic [POS_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[15:0];
    endfunction

    cet_pkg::t_mode   r_mode,  n_mode;
    logic [POS_W-1:0] r_start, n_start;
    logic [POS_W-1:0] r_pos,   n_pos;

    logic [7:0]                       b;
    logic [POS_W-1:0]                 p, nxt, st;
    logic                             handled, failed;
    logic [NSLOT-1:0]                 slot_v;
    cet_pkg::t_tok_item [NSLOT-1:0]   slot;
    logic [cet_pkg::RUN_CNT_W-1:0]    idx;

    // slot 0: token closed by this byte, 1: one-byte token, 2: close at end,
    // 3: end token
    always_comb begin
        b       = i_item.source_byte;
        p       = r_pos;
        nxt     = (p < MAX_P) ? p + POS_W'(1) : MAX_P;
        st      = r_start;
        handled = 1'b0;
        failed  = 1'b0;
        n_mode  = r_mode;
        n_start = r_start;
        slot_v  = '0;
        slot    = '0;

        case (r_mode)
            cet_pkg::MODE_DRAIN: begin
                handled = 1'b1;
            end
            cet_pkg::MODE_IDENT: begin
                if (cet_pkg::is_alpha(b) || cet_pkg::is_digit(b)) begin
                    handled = 1'b1;
                end else begin
                    slot_v[0] = 1'b1;
                    slot[0]   = cet_pkg::mk_tok(cet_pkg::K_IDENT, out16(st), out16(p - st));
                    n_mode    = cet_pkg::MODE_IDLE;
                end
            end
            cet_pkg::MODE_CONST: begin
                if (cet_pkg::is_digit(b)) begin
                    handled = 1'b1;
                end else begin
                    slot_v[0] = 1'b1;
                    slot[0]   = cet_pkg::mk_tok(cet_pkg::K_CONST, out16(st), out16(p - st));
                    n_mode    = cet_pkg::MODE_IDLE;
                end
            end
            cet_pkg::MODE_GT, cet_pkg::MODE_LT: begin
                n_mode    = cet_pkg::MODE_IDLE;
                slot_v[0] = 1'b1;
                if (b == cet_pkg::CH_EQ) begin
                    handled = 1'b1;
                    slot[0] = cet_pkg::mk_tok(
                        (r_mode == cet_pkg::MODE_GT) ? cet_pkg::K_GEQ : cet_pkg::K_LEQ,
                        out16(st), out16(nxt - st));
                end else begin
                    slot[0] = cet_pkg::mk_tok(
                        (r_mode == cet_pkg::MODE_GT) ? cet_pkg::K_GT : cet_pkg::K_LT,
                        out16(st), out16(p - st));
                end
            end
            cet_pkg::MODE_EQ, cet_pkg::MODE_BANG: begin
                handled   = 1'b1;
                slot_v[0] = 1'b1;
                if (b == cet_pkg::CH_EQ) begin
                    slot[0] = cet_pkg::mk_tok(
                        (r_mode == cet_pkg::MODE_EQ) ? cet_pkg::K_EQ : cet_pkg::K_NEQ,
                        out16(st), out16(nxt - st));
                    n_mode  = cet_pkg::MODE_IDLE;
                end else begin
                    slot[0] = cet_pkg::mk_tok(cet_pkg::K_EXPEQ, out16(st), 16'd1);
                    n_mode  = cet_pkg::MODE_DRAIN;
                end
            end
            default: begin
            end
        endcase

        if (!handled) begin
            n_start = p;
            if (cet_pkg::is_space(b)) begin
                n_mode = n_mode;
            end else if (b == cet_pkg::CH_MINUS) begin
                slot_v[1] = 1'b1;
                slot[1]   = cet_pkg::mk_tok(cet_pkg::K_MINUS, out16(p), out16(nxt - p));
            end else if (b == cet_pkg::CH_PLUS) begin
                slot_v[1] = 1'b1;
                slot[1]   = cet_pkg::mk_tok(cet_pkg::K_PLUS, out16(p), out16(nxt - p));
            end else if (b == cet_pkg::CH_GT) begin
                n_mode = cet_pkg::MODE_GT;
            end else if (b == cet_pkg::CH_LT) begin
                n_mode = cet_pkg::MODE_LT;
            end else if (b == cet_pkg::CH_EQ) begin
                n_mode = cet_pkg::MODE_EQ;
            end else if (b == cet_pkg::CH_BANG) begin
                n_mode = cet_pkg::MODE_BANG;
            end else if (cet_pkg::is_digit(b)) begin
                n_mode = cet_pkg::MODE_CONST;
            end else if (cet_pkg::is_alpha(b)) begin
                n_mode = cet_pkg::MODE_IDENT;
            end else begin
                slot_v[1] = 1'b1;
                slot[1]   = cet_pkg::mk_tok(cet_pkg::K_BAD, out16(p), 16'd1);
                n_mode    = cet_pkg::MODE_DRAIN;
            end
        end

        if (i_item.is_final) begin
            failed = (n_mode == cet_pkg::MODE_DRAIN);
            case (n_mode)
                cet_pkg::MODE_IDENT: begin
                    slot_v[2] = 1'b1;
                    slot[2] = cet_pkg::mk_tok(cet_pkg::K_IDENT, out16(n_start),
                                              out16(nxt - n_start));
                end
                cet_pkg::MODE_CONST: begin
                    slot_v[2] = 1'b1;
                    slot[2] = cet_pkg::mk_tok(cet_pkg::K_CONST, out16(n_start),
                                              out16(nxt - n_start));
                end
                cet_pkg::MODE_GT: begin
                    slot_v[2] = 1'b1;
                    slot[2] = cet_pkg::mk_tok(cet_pkg::K_GT, out16(n_start),
                                              out16(nxt - n_start));
                end
                cet_pkg::MODE_LT: begin
                    slot_v[2] = 1'b1;
                    slot[2] = cet_pkg::mk_tok(cet_pkg::K_LT, out16(n_start),
                                              out16(nxt - n_start));
                end
                cet_pkg::MODE_EQ, cet_pkg::MODE_BANG: begin
                    slot_v[2] = 1'b1;
                    slot[2] = cet_pkg::mk_tok(cet_pkg::K_EXPEQ, out16(n_start), 16'd1);
                    failed  = 1'b1;
                end
                default: begin
                end
            endcase
            slot_v[3] = !failed;
            slot[3]   = cet_pkg::mk_tok(cet_pkg::K_END, out16(nxt), 16'd0);
            n_mode    = cet_pkg::MODE_IDLE;
            n_start   = '0;
            n_pos     = '0;
        end else begin
            n_pos = nxt;
        end
    end

    // pack the valid slots in order and flag the last one
    always_comb begin
        idx   = '0;
        o_run = '0;
        for (int s = 0; s < NSLOT; s++) begin
            if (slot_v[s] && (idx != cet_pkg::RUN_CNT_W'(cet_pkg::MAX_RES))) begin
                o_run.tok[idx] = slot[s];
                idx            = idx + 1'b1;
            end
        end
        o_run.count = idx;
        if (idx != '0) begin
            o_run.tok[idx - 1'b1].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= cet_pkg::MODE_IDLE;
            r_start <= '0;
            r_pos   <= '0;
        end else if (i_adv) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
        end
    end

`ifndef SYNTHESIS
    a_final_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.is_final) |=>
            (r_pos == '0 && r_start == '0 && r_mode == cet_pkg::MODE_IDLE))
        else $error("scanner did not restart after final byte");
    a_drain_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == cet_pkg::MODE_DRAIN && !i_item.is_final) |-> (o_run.count == '0))
        else $error("results produced while dropping bytes");
    a_start_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start <= r_pos)
        else $error("token start beyond current position");
`endif
endmodule

/* rtl/cet_res_queue.sv */
// cet_res_queue: four-entry shifting result queue; takes a run of up to
// three tokens per transfer in, sends one token per transfer out.
// Depends on cet_pkg and cet_stream_if.
module cet_res_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cet_pkg::t_run i_run,
    output logic          o_room,
    cet_stream_if.source  o_tok
);
    localparam int QD = cet_pkg::QDEPTH;
    localparam int CW = cet_pkg::QCNT_W;

    cet_pkg::t_tok_item r_q [QD];
    cet_pkg::t_tok_item n_q [QD];
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      base;
    logic               pop;

    assign o_tok.valid = (r_cnt != '0);
    assign o_tok.data  = r_q[0];
    assign o_room      = (r_cnt + CW'(i_run.count)) <= CW'(QD);

    always_comb begin
        pop  = (r_cnt != '0) && o_tok.ready;
        base = r_cnt - CW'(pop);
        for (int i = 0; i < QD - 1; i++) begin
            n_q[i] = pop ? r_q[i + 1] : r_q[i];
        end
        n_q[QD - 1] = r_q[QD - 1];
        for (int i = 0; i < QD; i++) begin
            for (int k = 0; k < cet_pkg::MAX_RES; k++) begin
                if (i_push && (cet_pkg::RUN_CNT_W'(k) < i_run.count)
                        && ((base + CW'(k)) == CW'(i))) begin
                    n_q[i] = i_run.tok[k];
                end
            end
        end
        n_cnt = base + (i_push ? CW'(i_run.count) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("run pushed without room");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QD))
        else $error("result queue count out of range");
`endif
endmodule

/* rtl/comparison_expression_tokenizer.sv */
// Streaming tokenizer for comparison expressions: one source byte per transfer in,
// one token (kind, start offset, length, last-of-run flag) per transfer out.
// A byte is accepted every cycle while the result side keeps up; a byte can cause
// up to three tokens, which a four-entry result queue then sends one per cycle while
// o_tok is ready, holding off input while the queue lacks room for the next byte's
// run. A byte passes through the input register, then the single-pass scanner, which
// writes the queue. MAX_POS sets the saturation point of offsets and lengths.
module comparison_expression_tokenizer #(
    parameter longint unsigned MAX_POS = 65535
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cet_stream_if.sink   i_src,
    cet_stream_if.source o_tok
);
    logic               in_valid;
    cet_pkg::t_src_item in_item;
    cet_pkg::t_run      run;
    logic               room;
    logic               adv;

    assign adv = in_valid && room;

    cet_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (i_src),
        .i_take  (adv),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    cet_scan #(
        .MAX_POS (MAX_POS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (in_item),
        .o_run   (run)
    );

    cet_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (adv),
        .i_run   (run),
        .o_room  (room),
        .o_tok   (o_tok)
    );
endmodule
